// ===== rtl/lma_pkg.sv =====
// Package for the loss mean accumulator: loss kind codes and fixed constants.
// No dependencies.
package lma_pkg;
  localparam logic [1:0] KIND_SQ  = 2'd0;
  localparam logic [1:0] KIND_ABS = 2'd1;
  localparam logic [1:0] KIND_BCE = 2'd2;
  localparam logic [1:0] KIND_CE  = 2'd3;
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;
  localparam int unsigned MEAN_W = 47;
  localparam int unsigned CNT_W = 17;
  localparam int unsigned IN_W = 20;
endpackage

// ===== rtl/lma_if.sv =====
// Valid/ready channel interfaces for the loss mean accumulator.
// Depends on lma_pkg.
interface lma_in_if import lma_pkg::*; ();
  logic valid;
  logic ready;
  logic signed [IN_W-1:0] target;
  logic signed [IN_W-1:0] predicted;
  logic last_in_sample;
  logic last_in_set;
  modport source (output valid, target, predicted, last_in_sample, last_in_set, input ready);
  modport sink (input valid, target, predicted, last_in_sample, last_in_set, output ready);
endinterface

interface lma_out_if import lma_pkg::*; ();
  logic valid;
  logic ready;
  logic [MEAN_W-1:0] mean_loss;
  logic [CNT_W-1:0] sample_count;
  logic saturated;
  logic empty_set;
  modport source (output valid, mean_loss, sample_count, saturated, empty_set, input ready);
  modport sink (input valid, mean_loss, sample_count, saturated, empty_set, output ready);
endinterface

// ===== rtl/loss_mean_accumulator_core.sv =====
// Loss mean accumulator top level: per-element loss, saturating sum, mean.
// Depends on lma_pkg and the channels in lma_if.
//
// channel   dir  beat
// in        in   target, predicted, last_in_sample, last_in_set
// out       out  mean_loss, sample_count, saturated, empty_set (one per set)
// apb       in   loss_kind at address 0
//
// After a beat the input is not ready until the element is accumulated. Each
// -ln term runs on the shared multiplier after a normalize shift of
// 1..FRAC_BITS; cross-entropy computes one term and binary cross-entropy two.
// End of set adds a restoring division and the output, plus any stall on out.
// rst clears the state machine, the sum, the sample count, the overflow flag
// and loss_kind.
module loss_mean_accumulator_core import lma_pkg::*; #(
  parameter int MAX_SAMPLES = 65536,
  parameter int FRAC_BITS = 16,
  parameter int ACC_WIDTH = 48
) (
  input  logic        clk,
  input  logic        rst,
  lma_in_if.sink      in_ch,
  lma_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int FW = FRAC_BITS;
  localparam int CAP = (MAX_SAMPLES < 131071) ? MAX_SAMPLES : 131071;
  localparam int SW = $clog2(FW + 1);       // normalize shift width
  localparam int STW = $clog2(FW);          // squaring step counter width
  localparam int LW = SW + FW;              // log magnitude width
  localparam int TW = ((IN_W + 1 > FW + 2) ? IN_W + 1 : FW + 2) + 1;
  localparam int MA0 = (TW > LW + 1) ? TW : LW + 1;
  localparam int MA = (MA0 > IN_W + 2) ? MA0 : IN_W + 2;
  localparam int MB = 33;
  localparam int PW = MA + MB;
  localparam int TMW = PW + 1;
  localparam int EW = TMW - FW;
  localparam int XW = ((ACC_WIDTH > EW) ? ACC_WIDTH : EW) + 1;
  localparam int DW = $clog2(ACC_WIDTH);
  localparam logic signed [ACC_WIDTH-1:0] ACC_HI = {1'b0, {(ACC_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_WIDTH-1:0] ACC_LO = {1'b1, {(ACC_WIDTH-1){1'b0}}};
  localparam logic [FW+1:0] ONE = (FW+2)'(1) << FW;
  localparam logic signed [TW-1:0] ONE_S = TW'(1) << FW;
  localparam logic [63:0] MEAN_MAX = (64'd1 << MEAN_W) - 64'd1;
  localparam logic [CNT_W-1:0] CAP_V = CNT_W'(CAP);

  localparam logic [3:0] S_IDLE = 4'd0, S_SQE = 4'd1, S_SQW = 4'd2, S_LOAD = 4'd3,
    S_NORM = 4'd4, S_SQ = 4'd5, S_SQR = 4'd6, S_SCL = 4'd7, S_SCLW = 4'd8,
    S_TERM = 4'd9, S_TERMW = 4'd10, S_FIN = 4'd11, S_ACC = 4'd12, S_DSET = 4'd13,
    S_DIV = 4'd14, S_OUT = 4'd15;

  logic [3:0] state;
  logic [1:0] loss_kind, kind;
  logic signed [ACC_WIDTH-1:0] loss_sum;
  logic [CNT_W-1:0] samples_seen;
  logic sum_overflow;
  logic signed [IN_W:0] tv, pv;
  logic last_smp, last_set, second;
  logic [FW+1:0] m;
  logic [SW-1:0] sh;
  logic [STW-1:0] step;
  logic [FW-1:0] frac;
  logic [LW-1:0] nl;
  logic signed [PW-1:0] mul_p;
  logic signed [MA-1:0] mul_a;
  logic signed [MB-1:0] mul_b;
  logic signed [TMW-1:0] term;
  logic signed [EW-1:0] elem;
  logic [ACC_WIDTH-1:0] quo;
  logic [CNT_W-1:0] rem_;
  logic [DW-1:0] dcnt;

  assign pready = 1'b1;
  assign prdata = {30'd0, loss_kind};
  always_ff @(posedge clk) begin
    if (rst) loss_kind <= KIND_SQ;
    else if (psel && penable && pwrite && paddr == 2'd0) loss_kind <= pwdata[1:0];
  end

  assign in_ch.ready = (state == S_IDLE);
  assign out_ch.valid = (state == S_OUT);
  assign out_ch.mean_loss = (samples_seen == '0) ? '0 :
                            (64'(quo) > MEAN_MAX) ? {MEAN_W{1'b1}} : MEAN_W'(quo);
  assign out_ch.sample_count = samples_seen;
  assign out_ch.saturated = sum_overflow;
  assign out_ch.empty_set = (samples_seen == '0);

  // Shared multiplier with a registered product.
  always_ff @(posedge clk) mul_p <= mul_a * mul_b;

  logic signed [IN_W:0] pc;
  logic signed [IN_W+1:0] d;
  logic signed [TW-1:0] tw_s, onemt;
  logic [LW-1:0] mag;
  logic [FW+1:0] mq;
  logic signed [TMW-1:0] term_r;
  logic signed [XW-1:0] acc_sum;
  logic [CNT_W:0] rem_sh, rem_sub;
  always_comb begin
    d = {tv[IN_W], tv} - {pv[IN_W], pv};
    if (pv < 1) pc = (IN_W+1)'(1);
    else if (pv > $signed({1'b0, ONE}) - 1) pc = (IN_W+1)'($signed({1'b0, ONE}) - 1);
    else pc = pv;
    tw_s = TW'(tv);
    onemt = ONE_S - tw_s;
    mag = {sh, {FW{1'b0}}} - {{SW{1'b0}}, frac};
    mq = mul_p[FW +: FW+2];
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_SQE: begin
        mul_a = MA'(d);
        mul_b = MB'(d);
      end
      S_SQ: begin
        mul_a = MA'($signed({1'b0, m}));
        mul_b = MB'($signed({1'b0, m}));
      end
      S_SCL: begin
        mul_a = MA'($signed({1'b0, mag}));
        mul_b = $signed({1'b0, LN2_Q32});
      end
      S_TERM: begin
        mul_a = second ? MA'(onemt) : MA'(tw_s);
        mul_b = MB'($signed({1'b0, nl}));
      end
      default: ;
    endcase
    // The per-element division by ONE truncates toward zero.
    term_r = term[TMW-1] ? (term + $signed(TMW'({FW{1'b1}}))) >>> FW : term >>> FW;
    acc_sum = XW'(loss_sum) + XW'(elem);
    rem_sh = {rem_, quo[ACC_WIDTH-1]};
    rem_sub = rem_sh - {1'b0, samples_seen};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; loss_sum <= '0; samples_seen <= '0; sum_overflow <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (in_ch.valid) begin
          tv <= {in_ch.target[IN_W-1], in_ch.target};
          pv <= {in_ch.predicted[IN_W-1], in_ch.predicted};
          last_smp <= in_ch.last_in_sample; last_set <= in_ch.last_in_set;
          kind <= loss_kind; second <= 1'b0; term <= '0;
          state <= (loss_kind == KIND_SQ || loss_kind == KIND_ABS) ? S_SQE : S_LOAD;
        end
        S_SQE: begin
          if (kind == KIND_ABS) begin
            elem <= EW'(d[IN_W+1] ? -d : d);
            state <= S_ACC;
          end else state <= S_SQW;
        end
        S_SQW: begin
          elem <= EW'(mul_p >>> FW);
          state <= S_ACC;
        end
        S_LOAD: begin
          m <= second ? (FW+2)'(ONE_S - TW'(pc)) : (FW+2)'(pc);
          sh <= '0; frac <= '0; step <= '0; state <= S_NORM;
        end
        S_NORM: if (m < ONE) begin m <= m << 1; sh <= sh + 1'b1; end
                else state <= S_SQ;
        S_SQ: state <= S_SQR;
        S_SQR: begin
          // A square at or above 2.0 gives a one bit and is halved.
          if (mq[FW+1]) begin
            m <= mq >> 1;
            frac <= {frac[FW-2:0], 1'b1};
          end else begin
            m <= mq;
            frac <= {frac[FW-2:0], 1'b0};
          end
          step <= step + 1'b1;
          state <= (step == STW'(FW - 1)) ? S_SCL : S_SQ;
        end
        S_SCL: state <= S_SCLW;
        S_SCLW: begin
          nl <= mul_p[32 +: LW];
          state <= S_TERM;
        end
        S_TERM: state <= S_TERMW;
        S_TERMW: begin
          term <= term + TMW'(mul_p);
          if (kind == KIND_BCE && !second) begin
            second <= 1'b1;
            state <= S_LOAD;
          end else state <= S_FIN;
        end
        S_FIN: begin
          elem <= EW'(term_r);
          state <= S_ACC;
        end
        S_ACC: begin
          if (acc_sum > XW'(ACC_HI)) begin
            loss_sum <= ACC_HI; sum_overflow <= 1'b1;
          end else if (acc_sum < XW'(ACC_LO)) begin
            loss_sum <= ACC_LO; sum_overflow <= 1'b1;
          end else loss_sum <= ACC_WIDTH'(acc_sum);
          if ((last_smp || last_set) && samples_seen < CAP_V)
            samples_seen <= samples_seen + 1'b1;
          state <= last_set ? S_DSET : S_IDLE;
        end
        S_DSET: begin
          // A sum at or below zero divides as zero.
          quo <= (loss_sum > 0) ? $unsigned(loss_sum) : '0;
          rem_ <= '0; dcnt <= '0; state <= S_DIV;
        end
        S_DIV: begin
          if (rem_sh >= {1'b0, samples_seen}) begin
            rem_ <= rem_sub[CNT_W-1:0];
            quo <= {quo[ACC_WIDTH-2:0], 1'b1};
          end else begin
            rem_ <= rem_sh[CNT_W-1:0];
            quo <= {quo[ACC_WIDTH-2:0], 1'b0};
          end
          dcnt <= dcnt + 1'b1;
          if (dcnt == DW'(ACC_WIDTH - 1)) state <= S_OUT;
        end
        S_OUT: if (out_ch.ready) begin
          loss_sum <= '0; samples_seen <= '0; sum_overflow <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule
